/* sv/irpd_pkg.sv */
// Shared constants for the IR pulse-distance decoder: field widths,
// register indexes, reset values and decoder phase codes. No dependencies.
package irpd_pkg;

	// Field widths
	localparam int unsigned TolW   = 12;
	localparam int unsigned TimeW  = 16;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned DataW  = 16;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned WordW  = 32;
	localparam int unsigned CountW = 5;
	localparam int unsigned PhaseW = 2;

	// Configuration register indexes
	localparam logic [IdxW-1:0] REG_TOLERANCE = 3'd0;
	localparam logic [IdxW-1:0] REG_START_NOM = 3'd1;
	localparam logic [IdxW-1:0] REG_REPEAT_NOM = 3'd2;
	localparam logic [IdxW-1:0] REG_ZERO_NOM = 3'd3;
	localparam logic [IdxW-1:0] REG_ONE_NOM = 3'd4;

	// Register reset values, microseconds
	localparam logic [TolW-1:0]  TOL_RST    = 12'd500;
	localparam logic [TimeW-1:0] START_RST  = 16'd13500;
	localparam logic [TimeW-1:0] REPEAT_RST = 16'd11250;
	localparam logic [TimeW-1:0] ZERO_RST   = 16'd1120;
	localparam logic [TimeW-1:0] ONE_RST    = 16'd2250;

	// Decoder phases; the unused code behaves like idle
	localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
	localparam logic [PhaseW-1:0] PH_WAIT = 2'd1;
	localparam logic [PhaseW-1:0] PH_DATA = 2'd2;

	// Last data bit of a frame
	localparam logic [CountW-1:0] LAST_BIT = 5'(WordW - 1);

endpackage

/* sv/ir_pulse_distance_decoder_unit.sv */
// Top level of the IR pulse-distance (NEC-style) remote decoder.
// Depends on irpd_pkg and irpd_window.
//
// Usage:
//   Each request on the input channel (in_valid/in_ready, field interval) is
//   one falling edge of the IR receiver with the microseconds since the
//   previous edge, saturated by the sender at 65535. Every request yields
//   exactly one result on the output channel (out_valid/out_ready) carrying
//   frame_ready, repeat_ready and the address/command of the last frame that
//   passed the inverse-byte check.
//   A request accepted into the input stage is registered there, then
//   classified and folded into the decoder state once the output register is
//   free or being taken; its result is visible until taken. Throughput is
//   one request per cycle while the receiver keeps taking results.
//   When the receiver stalls, the result stays in the output register and
//   the input stage can still hold one more request; after that in_ready
//   drops until the output is taken.
//   Reset (arst_n low) returns the timing registers to their defaults
//   (500/13500/11250/1120/2250 us), the decoder to idle and clears the
//   reported address and command. Registers are set via cfg_we, cfg_index,
//   cfg_data; the user writes only while no request is in flight (unchecked).
module ir_pulse_distance_decoder_unit import irpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [DataW-1:0] cfg_data,
	// edge requests
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [TimeW-1:0] interval,
	// results
	output logic             out_valid,
	input  logic             out_ready,
	output logic             frame_ready,
	output logic             repeat_ready,
	output logic [ByteW-1:0] address,
	output logic [ByteW-1:0] command
);

	logic [TolW-1:0]   tol_q;
	logic [TimeW-1:0]  start_nom_q;
	logic [TimeW-1:0]  repeat_nom_q;
	logic [TimeW-1:0]  zero_nom_q;
	logic [TimeW-1:0]  one_nom_q;

	logic              valid_s1;
	logic [TimeW-1:0]  interval_s1;
	logic              adv_s1;

	logic [PhaseW-1:0] phase_q;
	logic [CountW-1:0] bit_count_q;
	logic [WordW-1:0]  shift_word_q;
	logic [ByteW-1:0]  last_address_q;
	logic [ByteW-1:0]  last_command_q;
	logic              out_valid_q;
	logic              frame_q;
	logic              repeat_q;

	logic              start_hit;
	logic              repeat_hit;
	logic              zero_hit;
	logic              one_hit;

	logic [PhaseW-1:0] phase_nx;
	logic [CountW-1:0] bit_count_nx;
	logic [WordW-1:0]  shift_word_nx;
	logic [ByteW-1:0]  last_address_nx;
	logic [ByteW-1:0]  last_command_nx;
	logic              frame_nx;
	logic              repeat_nx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q        <= TOL_RST;
			start_nom_q  <= START_RST;
			repeat_nom_q <= REPEAT_RST;
			zero_nom_q   <= ZERO_RST;
			one_nom_q    <= ONE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOLERANCE:  tol_q        <= cfg_data[TolW-1:0];
				REG_START_NOM:  start_nom_q  <= cfg_data[TimeW-1:0];
				REG_REPEAT_NOM: repeat_nom_q <= cfg_data[TimeW-1:0];
				REG_ZERO_NOM:   zero_nom_q   <= cfg_data[TimeW-1:0];
				REG_ONE_NOM:    one_nom_q    <= cfg_data[TimeW-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: input stage moves on when the output register is free or drains
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			interval_s1 <= interval;
		end
	end

	// Window checks
	irpd_window u_win_start (
		.t(interval_s1), .nominal(start_nom_q), .tol(tol_q), .hit(start_hit)
	);
	irpd_window u_win_repeat (
		.t(interval_s1), .nominal(repeat_nom_q), .tol(tol_q), .hit(repeat_hit)
	);
	irpd_window u_win_zero (
		.t(interval_s1), .nominal(zero_nom_q), .tol(tol_q), .hit(zero_hit)
	);
	irpd_window u_win_one (
		.t(interval_s1), .nominal(one_nom_q), .tol(tol_q), .hit(one_hit)
	);

	// Decoder next state
	always_comb begin
		phase_nx        = phase_q;
		bit_count_nx    = bit_count_q;
		shift_word_nx   = shift_word_q;
		last_address_nx = last_address_q;
		last_command_nx = last_command_q;
		frame_nx        = 1'b0;
		repeat_nx       = 1'b0;
		case (phase_q)
			PH_WAIT: begin
				// start wins over repeat; anything else keeps waiting
				if (start_hit) begin
					phase_nx     = PH_DATA;
					bit_count_nx = '0;
				end else if (repeat_hit) begin
					repeat_nx = 1'b1;
					phase_nx  = PH_IDLE;
				end
			end
			PH_DATA: begin
				if (!zero_hit && !one_hit) begin
					bit_count_nx = '0;
					phase_nx     = PH_WAIT;
				end else begin
					// zero wins over one
					shift_word_nx[bit_count_q] = !zero_hit;
					if (bit_count_q == LAST_BIT) begin
						bit_count_nx = '0;
						phase_nx     = PH_IDLE;
						if (shift_word_nx[7:0] == ~shift_word_nx[15:8] &&
						    shift_word_nx[23:16] == ~shift_word_nx[31:24]) begin
							last_address_nx = shift_word_nx[7:0];
							last_command_nx = shift_word_nx[23:16];
							frame_nx        = 1'b1;
						end
					end else begin
						bit_count_nx = bit_count_q + 1'b1;
					end
				end
			end
			default: begin
				// idle or unused code: edge only arms the decoder
				phase_nx     = PH_WAIT;
				bit_count_nx = '0;
			end
		endcase
	end

	// Decoder state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bit_count_q    <= '0;
			shift_word_q   <= '0;
			last_address_q <= '0;
			last_command_q <= '0;
			out_valid_q    <= 1'b0;
			frame_q        <= 1'b0;
			repeat_q       <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_q        <= phase_nx;
				bit_count_q    <= bit_count_nx;
				shift_word_q   <= shift_word_nx;
				last_address_q <= last_address_nx;
				last_command_q <= last_command_nx;
				frame_q        <= frame_nx;
				repeat_q       <= repeat_nx;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The state only moves with a new result, so the last frame bytes stay put
	// while a result waits
	assign out_valid    = out_valid_q;
	assign frame_ready  = frame_q;
	assign repeat_ready = repeat_q;
	assign address      = last_address_q;
	assign command      = last_command_q;

	// Checks
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(frame_q && repeat_q))
		else $error("frame and repeat reported together");

	a_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (phase_q == PH_IDLE)) |=> (phase_q == PH_WAIT))
		else $error("edge in idle did not arm the decoder");

	a_count_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_count_q != '0) |-> (phase_q == PH_DATA))
		else $error("bit count nonzero outside data phase");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("processed edge produced no result");

endmodule

/* sv/irpd_window.sv */
// Strict timing window check: max(nominal - tol, 0) < t < nominal + tol.
// Depends on irpd_pkg.
module irpd_window import irpd_pkg::*; (
	input  logic [TimeW-1:0] t,
	input  logic [TimeW-1:0] nominal,
	input  logic [TolW-1:0]  tol,
	output logic             hit
);

	logic [TimeW-1:0] tol_ext;
	logic [TimeW-1:0] lo;
	logic [TimeW:0]   hi;

	// Lower bound floors at zero, upper bound carries one extra bit
	always_comb begin
		tol_ext = TimeW'(tol);
		lo = (nominal > tol_ext) ? (nominal - tol_ext) : '0;
		hi = {1'b0, nominal} + {1'b0, tol_ext};
		hit = (t > lo) && ({1'b0, t} < hi);
	end

endmodule
